// ===== rtl/core/bpfa_pkg.sv =====
// shared types and constants of the bitmap page frame allocator
// used by every other module under rtl/core except bpfa_bitmap_mem, no dependencies
package bpfa_pkg;

    localparam int MAX_PAGES_DEF  = 4096;
    localparam int WORD_BITS_DEF  = 64;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int ADDR_W       = 64;
    localparam int PAGE_COUNT_W = 13;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAGE_COUNT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED_END = 2'd2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FRAME = 2'd1,
        ST_BAD_ADDR = 2'd2
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic    init_load;
        logic    free_load;
        logic    scan_load;
        logic    resv_load;
        logic    sweep_run;
        logic    scan_run;
        logic    alloc_wb;
        logic    div_start;
        logic    free_rd;
        logic    free_wr;
        logic    post_en;
        logic    post_addr;
        status_t post_stat;
        logic    out_load;
    } bpfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic free_bad;
        logic sweep_done;
    } bpfa_stat_t;

endpackage

// ===== rtl/core/bpfa_bitmap_mem.sv =====
// usage bitmap store: one word per row, registered read, per-row valid bits
// a row that is not valid reads as all zero; depends on nothing
module bpfa_bitmap_mem #(
    parameter int NWORDS    = 64,
    parameter int WORD_BITS = 64,
    localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WORD_BITS-1:0] word
);

    logic [WORD_BITS-1:0] mem [NWORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [NWORDS-1:0]    valid_reg;
    logic                 rvalid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvalid_reg <= valid_reg[raddr];
            end
        end
    end

    assign word = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== rtl/core/bpfa_datapath.sv =====
// datapath: config registers, hint, reserved count, scan pipeline, page index split,
// result staging and output word; depends on bpfa_pkg and bpfa_bitmap_mem
module bpfa_datapath #(
    parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
    parameter int WORD_BITS  = bpfa_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [bpfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]        cfg_data,
    input  logic [bpfa_pkg::ADDR_W-1:0]        frame_address,
    input  bpfa_pkg::bpfa_cmd_t                cmd,
    output bpfa_pkg::bpfa_stat_t               stat,
    output logic [bpfa_pkg::ADDR_W-1:0]        result_address,
    output logic [bpfa_pkg::STATUS_W-1:0]      status
);

    import bpfa_pkg::*;

    localparam int NWORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int QW     = $clog2(NWORDS + 1);
    localparam int HW     = $clog2(MAX_PAGES + 1);
    localparam int HW1    = HW + 1;
    localparam int BW     = $clog2(WORD_BITS);
    localparam int CW     = (HW > PAGE_COUNT_W) ? HW : PAGE_COUNT_W;
    localparam int RSH    = HW + BW;
    localparam int RW     = HW + 1;
    localparam int PW     = HW + RW;
    localparam int RECIP  = (2 ** RSH + WORD_BITS - 1) / WORD_BITS;

    // configuration
    logic [ADDR_W-1:0]       base_reg;
    logic [PAGE_COUNT_W-1:0] pcount_reg;
    logic [ADDR_W-1:0]       resv_end_reg;

    // allocation hint, kept both as page index and as word/bit pair
    logic [HW-1:0] hint_reg;
    logic [QW-1:0] hint_word_reg;
    logic [BW-1:0] hint_bit_reg;

    logic [ADDR_W-1:0] diff_reg;
    logic              borrow_reg;
    logic [HW-1:0]     rem_reg;
    logic [QW-1:0]     ptr_reg;
    logic [HW-1:0]     idx_reg;
    logic [WW-1:0]     quot_reg;

    // scan pipeline
    logic [WW-1:0] rd_ptr_reg;
    logic [HW-1:0] rd_base_reg;
    logic [QW-1:0] rd_left_reg;
    logic          chk_vld_reg;
    logic [WW-1:0] chk_word_reg;
    logic [HW-1:0] chk_base_reg;

    logic [WW-1:0]        found_word_reg;
    logic [HW-1:0]        found_base_reg;
    logic [BW-1:0]        found_bit_reg;
    logic [WORD_BITS-1:0] found_data_reg;

    logic [ADDR_W-1:0]   res_reg;
    logic [STATUS_W-1:0] stat_reg;

    logic [HW-1:0]      npages;
    logic [CW-1:0]      pcount_ext;
    logic [ADDR_W-1:0]  sub_a;
    logic [ADDR_W:0]    sub_diff;
    logic [ADDR_W-1:0]  resv_pages;
    logic [HW-1:0]      resv_sat;
    logic [ADDR_W-1:0]  free_pages;
    logic               sweep_full;
    logic               sweep_zero;
    logic [WORD_BITS-1:0] part_mask;
    logic [WW-1:0]      start_word;
    logic [HW-1:0]      start_base;
    logic               start_wrap;
    logic [WORD_BITS-1:0] mem_word;
    logic               zany;
    logic [BW-1:0]      zpos;
    logic               hit;
    logic               issue;
    logic               rd_last;
    logic [HW-1:0]      alloc_idx;
    logic [HW-1:0]      page_idx;
    logic [PW-1:0]      recip_prod;
    logic [WW-1:0]      div_quot;
    logic [HW-1:0]      div_rem;

    logic                 mem_we;
    logic [WW-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WW-1:0]        mem_raddr;

    assign pcount_ext = CW'(pcount_reg);
    assign npages     = (pcount_ext > CW'(MAX_PAGES)) ? HW'(MAX_PAGES) : HW'(pcount_reg);

    // one shared subtractor: reserved end or freed address, minus base
    assign sub_a    = cmd.init_load ? resv_end_reg : frame_address;
    assign sub_diff = {1'b0, sub_a} - {1'b0, base_reg};

    // reserved page count, rounded up and saturated at the page count
    assign resv_pages = (diff_reg >> PAGE_SHIFT) + ADDR_W'(|diff_reg[PAGE_SHIFT-1:0]);
    always_comb
    begin
        if (borrow_reg)
        begin
            resv_sat = '0;
        end
        else if (resv_pages > ADDR_W'(npages))
        begin
            resv_sat = npages;
        end
        else
        begin
            resv_sat = resv_pages[HW-1:0];
        end
    end

    assign free_pages = diff_reg >> PAGE_SHIFT;

    // word and bit of the freed page through a reciprocal, exact for every page index
    assign page_idx   = diff_reg[PAGE_SHIFT +: HW];
    assign recip_prod = PW'(page_idx) * PW'(RECIP);
    assign div_quot   = recip_prod[RSH +: WW];
    assign div_rem    = page_idx - HW'(div_quot) * HW'(WORD_BITS);

    assign sweep_full = rem_reg >= HW'(WORD_BITS);
    assign sweep_zero = rem_reg == '0;
    assign part_mask  = ~({WORD_BITS{1'b1}} << rem_reg[BW-1:0]);

    assign start_wrap = hint_word_reg >= QW'(NWORDS);
    assign start_word = start_wrap ? '0 : hint_word_reg[WW-1:0];
    assign start_base = start_wrap ? '0 : (hint_reg - HW'(hint_bit_reg));

    // lowest clear bit of the word under check
    always_comb
    begin
        zany = 1'b0;
        zpos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (!mem_word[b])
            begin
                zany = 1'b1;
                zpos = BW'(b);
            end
        end
    end

    assign hit     = chk_vld_reg && zany &&
                     (({1'b0, chk_base_reg} + HW1'(zpos)) < {1'b0, npages});
    assign issue   = (rd_left_reg != '0) && !hit;
    assign rd_last = rd_ptr_reg == WW'(NWORDS - 1);

    assign alloc_idx = found_base_reg + HW'(found_bit_reg);

    assign stat.scan_hit   = hit;
    assign stat.scan_miss  = !chk_vld_reg && (rd_left_reg == '0);
    assign stat.free_bad   = borrow_reg || (free_pages >= ADDR_W'(npages));
    assign stat.sweep_done = !sweep_full;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (cmd.sweep_run && !sweep_zero)
        begin
            mem_we    = 1'b1;
            mem_waddr = ptr_reg[WW-1:0];
            mem_wdata = sweep_full ? {WORD_BITS{1'b1}} : part_mask;
        end
        else if (cmd.alloc_wb)
        begin
            mem_we    = 1'b1;
            mem_waddr = found_word_reg;
            mem_wdata = found_data_reg | (WORD_BITS'(1) << found_bit_reg);
        end
        else if (cmd.free_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = quot_reg;
            mem_wdata = mem_word & ~(WORD_BITS'(1) << rem_reg[BW-1:0]);
        end
        if (cmd.scan_run && issue)
        begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_reg;
        end
        else if (cmd.free_rd)
        begin
            mem_re    = 1'b1;
            mem_raddr = quot_reg;
        end
    end

    bpfa_bitmap_mem #(
        .NWORDS    (NWORDS),
        .WORD_BITS (WORD_BITS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cmd.init_load),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .word  (mem_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg     <= '0;
            pcount_reg   <= '0;
            resv_end_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS: base_reg     <= cfg_data;
                CFG_PAGE_COUNT:   pcount_reg   <= cfg_data[PAGE_COUNT_W-1:0];
                CFG_RESERVED_END: resv_end_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg      <= '0;
            hint_word_reg <= '0;
            hint_bit_reg  <= '0;
        end
        else if (cmd.resv_load)
        begin
            hint_reg <= resv_sat;
        end
        else if (cmd.sweep_run && !sweep_full)
        begin
            hint_word_reg <= ptr_reg;
            hint_bit_reg  <= rem_reg[BW-1:0];
        end
        else if (cmd.alloc_wb)
        begin
            hint_reg <= alloc_idx + HW'(1);
            if (found_bit_reg == BW'(WORD_BITS - 1))
            begin
                hint_word_reg <= QW'(found_word_reg) + QW'(1);
                hint_bit_reg  <= '0;
            end
            else
            begin
                hint_word_reg <= QW'(found_word_reg);
                hint_bit_reg  <= found_bit_reg + BW'(1);
            end
        end
        else if (cmd.free_wr && (idx_reg < hint_reg))
        begin
            hint_reg      <= idx_reg;
            hint_word_reg <= QW'(quot_reg);
            hint_bit_reg  <= rem_reg[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_left_reg <= '0;
            chk_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.scan_load)
            begin
                rd_left_reg <= QW'(NWORDS);
                chk_vld_reg <= 1'b0;
            end
            else if (cmd.scan_run)
            begin
                chk_vld_reg <= issue;
                if (issue)
                begin
                    rd_left_reg <= rd_left_reg - QW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init_load || cmd.free_load)
        begin
            diff_reg   <= sub_diff[ADDR_W-1:0];
            borrow_reg <= sub_diff[ADDR_W];
        end

        if (cmd.resv_load)
        begin
            rem_reg <= resv_sat;
            ptr_reg <= '0;
        end
        else if (cmd.sweep_run && sweep_full)
        begin
            rem_reg <= rem_reg - HW'(WORD_BITS);
            ptr_reg <= ptr_reg + QW'(1);
        end
        else if (cmd.div_start)
        begin
            rem_reg  <= div_rem;
            idx_reg  <= page_idx;
            quot_reg <= div_quot;
        end

        if (cmd.scan_load)
        begin
            rd_ptr_reg  <= start_word;
            rd_base_reg <= start_base;
        end
        else if (cmd.scan_run && issue)
        begin
            chk_word_reg <= rd_ptr_reg;
            chk_base_reg <= rd_base_reg;
            rd_ptr_reg   <= rd_last ? '0 : rd_ptr_reg + WW'(1);
            rd_base_reg  <= rd_last ? '0 : rd_base_reg + HW'(WORD_BITS);
        end

        if (cmd.scan_run && hit)
        begin
            found_word_reg <= chk_word_reg;
            found_base_reg <= chk_base_reg;
            found_bit_reg  <= zpos;
            found_data_reg <= mem_word;
        end

        if (cmd.post_en)
        begin
            res_reg  <= cmd.post_addr ? (base_reg + (ADDR_W'(alloc_idx) << PAGE_SHIFT)) : '0;
            stat_reg <= cmd.post_stat;
        end

        if (cmd.out_load)
        begin
            result_address <= res_reg;
            status         <= stat_reg;
        end
    end

endmodule

// ===== rtl/core/bpfa_ctrl.sv =====
// controller: operation sequencing and the output word handshake
// depends on bpfa_pkg
module bpfa_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic [bpfa_pkg::OPCODE_W-1:0]   s_tuser,
    output logic                            s_tready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output bpfa_pkg::bpfa_cmd_t             cmd,
    input  bpfa_pkg::bpfa_stat_t            stat
);

    import bpfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT_CHK,
        S_SWEEP,
        S_SCAN,
        S_ALLOC_WB,
        S_FREE_CHK,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    accept;
    opcode_t op;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = out_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign op       = opcode_t'(s_tuser);

    always_comb
    begin
        cmd            = '0;
        cmd.post_stat  = ST_DONE;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_INIT:
                        begin
                            cmd.init_load = 1'b1;
                            state_next    = S_INIT_CHK;
                        end
                        OP_ALLOC:
                        begin
                            cmd.scan_load = 1'b1;
                            state_next    = S_SCAN;
                        end
                        OP_FREE:
                        begin
                            cmd.free_load = 1'b1;
                            state_next    = S_FREE_CHK;
                        end
                        default:
                        begin
                            cmd.post_en = 1'b1;
                            state_next  = S_FINISH;
                        end
                    endcase
                end
            end
            S_INIT_CHK:
            begin
                cmd.resv_load = 1'b1;
                state_next    = S_SWEEP;
            end
            S_SWEEP:
            begin
                cmd.sweep_run = 1'b1;
                if (stat.sweep_done)
                begin
                    cmd.post_en = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = S_ALLOC_WB;
                end
                else if (stat.scan_miss)
                begin
                    cmd.post_en   = 1'b1;
                    cmd.post_stat = ST_NO_FRAME;
                    state_next    = S_FINISH;
                end
            end
            S_ALLOC_WB:
            begin
                cmd.alloc_wb  = 1'b1;
                cmd.post_en   = 1'b1;
                cmd.post_addr = 1'b1;
                state_next    = S_FINISH;
            end
            S_FREE_CHK:
            begin
                if (stat.free_bad)
                begin
                    cmd.post_en   = 1'b1;
                    cmd.post_stat = ST_BAD_ADDR;
                    state_next    = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_FREE_RD;
                end
            end
            S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
                state_next  = S_FREE_WR;
            end
            S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
                cmd.post_en = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                // output register free or being drained this cycle
                if (!out_valid_reg || m_tready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/bitmap_page_frame_allocator.sv =====
// top level of the bitmap page frame allocator, next-fit scan
// depends on bpfa_pkg, bpfa_ctrl, bpfa_datapath (and bpfa_bitmap_mem below it)
//
//  channel  direction  handshake          payload
//  s_*      in         s_tvalid/s_tready  s_tdata frame_address, s_tuser opcode
//  m_*      out        m_tvalid/m_tready  m_tdata result_address, m_tuser status
//  cfg_*    in         cfg_valid/ready    cfg_index register, cfg_data value
//
// one word at a time; each operation runs from the accepting edge to the result in the output register:
// init sweeps the reserved words, alloc reads bitmap words from the hint, at most the
// bitmap word count (one read per cycle), free checks the address, then reads and rewrites
// one word when it is in range, other opcode goes straight to the result
// reset empties the bitmap at once through per-word valid bits
// a result still waiting on m_tready stalls the next one in its last cycle;
// config is always ready
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = bpfa_pkg::MAX_PAGES_DEF,
    parameter int WORD_BITS  = bpfa_pkg::WORD_BITS_DEF,
    parameter int PAGE_SHIFT = bpfa_pkg::PAGE_SHIFT_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bpfa_pkg::ADDR_W-1:0]      s_tdata,   // [63:0] frame_address
    input  logic [bpfa_pkg::OPCODE_W-1:0]    s_tuser,   // [1:0] opcode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bpfa_pkg::ADDR_W-1:0]      m_tdata,   // [63:0] result_address
    output logic [bpfa_pkg::STATUS_W-1:0]    m_tuser,   // [1:0] status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bpfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]      cfg_data
);

    import bpfa_pkg::*;

    bpfa_cmd_t  cmd;
    bpfa_stat_t stat;

    assign cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bpfa_datapath #(
        .MAX_PAGES  (MAX_PAGES),
        .WORD_BITS  (WORD_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .frame_address  (s_tdata),
        .cmd            (cmd),
        .stat           (stat),
        .result_address (m_tdata),
        .status         (m_tuser)
    );

endmodule

// ===== sim/bitmap_page_frame_allocator_checker.sv =====
// checker for the bitmap page frame allocator: watches the request, result and
// config channels, predicts every result and compares it field by field
// depends on bpfa_pkg only
module bitmap_page_frame_allocator_checker
    import bpfa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [ADDR_W-1:0]      s_tdata,
    input  logic [OPCODE_W-1:0]    s_tuser,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [ADDR_W-1:0]      m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]      cfg_data,
    output int                     pending,
    output int                     errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES  = MAX_PAGES_DEF;
    localparam int WBITS  = WORD_BITS_DEF;
    localparam int PSHIFT = PAGE_SHIFT_DEF;
    localparam int NWORDS = (PAGES + WBITS - 1) / WBITS;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        status_t           stat;
    } frame_result_t;

    logic [ADDR_W-1:0]       win_base;
    logic [PAGE_COUNT_W-1:0] win_pages;
    logic [ADDR_W-1:0]       resv_limit;
    logic [WBITS-1:0]        used_map [NWORDS];
    int                      scan_hint;
    frame_result_t           frame_results_due [$];
    int                      fail_count;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    // lowest clear page in one word, -1 when there is none or it is not below the page count
    function automatic int lowest_free(input int w, input int npages);
        for (int b = 0; b < WBITS; b++)
        begin
            if (!used_map[w][b])
                return (w * WBITS + b < npages) ? w * WBITS + b : -1;
        end
        return -1;
    endfunction

    function automatic frame_result_t apply_frame_op(input opcode_t op,
                                                     input logic [63:0] addr);
        frame_result_t r;
        int            npages;
        int            total;
        int            first_word;
        int            found;
        int            page;
        logic [63:0]   diff;
        logic [63:0]   resv;
        logic [63:0]   idx;
        r.addr = '0;
        r.stat = ST_DONE;
        npages = (win_pages > PAGES) ? PAGES : int'(win_pages);
        case (op)
            OP_INIT:
            begin
                for (int w = 0; w < NWORDS; w++)
                    used_map[w] = '0;
                resv = '0;
                if (resv_limit > win_base)
                begin
                    diff = resv_limit - win_base;
                    resv = diff >> PSHIFT;
                    if (diff[PSHIFT-1:0] != '0)
                        resv = resv + 64'd1;
                end
                if (resv > 64'(npages))
                    resv = 64'(npages);
                for (int i = 0; i < int'(resv); i++)
                    used_map[i / WBITS][i % WBITS] = 1'b1;
                scan_hint = int'(resv);
            end
            OP_ALLOC:
            begin
                total = (npages + WBITS - 1) / WBITS;
                first_word = scan_hint / WBITS;
                found = -1;
                for (int w = first_word; w < total && found < 0; w++)
                    found = lowest_free(w, npages);
                // wrapped part of the next-fit scan
                for (int w = 0; w < first_word && w < total && found < 0; w++)
                    found = lowest_free(w, npages);
                if (found < 0)
                    r.stat = ST_NO_FRAME;
                else
                begin
                    used_map[found / WBITS][found % WBITS] = 1'b1;
                    scan_hint = found + 1;
                    r.addr = win_base + (64'(found) << PSHIFT);
                end
            end
            OP_FREE:
            begin
                if (addr < win_base)
                    r.stat = ST_BAD_ADDR;
                else
                begin
                    idx = (addr - win_base) >> PSHIFT;
                    if (idx >= 64'(npages))
                        r.stat = ST_BAD_ADDR;
                    else
                    begin
                        page = int'(idx);
                        used_map[page / WBITS][page % WBITS] = 1'b0;
                        if (page < scan_hint)
                            scan_hint = page;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t due;
        if (!rst_n)
        begin
            win_base = '0;
            win_pages = '0;
            resv_limit = '0;
            for (int w = 0; w < NWORDS; w++)
                used_map[w] = '0;
            scan_hint = 0;
            frame_results_due.delete();
            fail_count = 0;
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BASE_ADDRESS: win_base = cfg_data;
                    CFG_PAGE_COUNT:   win_pages = cfg_data[PAGE_COUNT_W-1:0];
                    CFG_RESERVED_END: resv_limit = cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // a result never belongs to a word taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (frame_results_due.size() == 0)
                    flag_mismatch("result with nothing due", m_tdata, '0);
                else
                begin
                    due = frame_results_due.pop_front();
                    if (m_tdata !== due.addr)
                        flag_mismatch("result_address", m_tdata, due.addr);
                    if (m_tuser !== due.stat)
                        flag_mismatch("status", 64'(m_tuser), 64'(due.stat));
                end
            end
            if (s_tvalid && s_tready)
                frame_results_due.push_back(apply_frame_op(opcode_t'(s_tuser), s_tdata));
            pending <= frame_results_due.size();
            errors <= fail_count;
        end
    end

endmodule

// ===== sim/bitmap_page_frame_allocator_tb.sv =====
// testbench top for the bitmap page frame allocator: clock, reset, stimulus
// and verdict; depends on bpfa_pkg, the allocator rtl and the checker module
module bitmap_page_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bpfa_pkg::*;

    localparam int                     PAGES      = MAX_PAGES_DEF;
    localparam int                     PSHIFT     = PAGE_SHIFT_DEF;
    localparam int                     STUCK_MAX  = 2000;
    localparam int                     PHASES     = 7;
    localparam int                     PHASE_LEN  = 60;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [ADDR_W-1:0]      s_tdata = '0;
    logic [OPCODE_W-1:0]    s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [ADDR_W-1:0]      m_tdata;
    logic [STATUS_W-1:0]    m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]      cfg_data = '0;

    int                     pending;
    int                     errors;
    int                     gap_pct = 20;
    int                     stuck = 0;
    logic [63:0]            cur_base = '0;
    int                     cur_pages = 0;

    bitmap_page_frame_allocator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bitmap_page_frame_allocator_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // no word moving on any channel for too long means the block hung
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck == STUCK_MAX)
        begin
            $display("** bitmap_page_frame_allocator: FAILED **");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic program_window(input logic [63:0] base, input logic [12:0] pages,
                                  input logic [63:0] resv_end);
        logic [CFG_INDEX_W-1:0] idx [4];
        logic [63:0]            val [4];
        idx[0] = CFG_BASE_ADDRESS;
        val[0] = base;
        idx[1] = CFG_PAGE_COUNT;
        val[1] = {$urandom, $urandom};
        val[1][12:0] = pages;
        idx[2] = CFG_RESERVED_END;
        val[2] = resv_end;
        idx[3] = CFG_UNUSED;
        val[3] = {$urandom, $urandom};
        for (int k = 0; k < 4; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_base = base;
        cur_pages = (pages > PAGES) ? PAGES : int'(pages);
    endtask

    task automatic send_request(input opcode_t op, input logic [63:0] addr);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= addr;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // wait for every result, block idle before touching config
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_free_addr();
        logic [63:0] a;
        int          r;
        r = $urandom_range(0, 99);
        a = {$urandom, $urandom};
        if (r < 70 && cur_pages > 0)
            a = cur_base + (64'($urandom_range(0, cur_pages - 1)) << PSHIFT) + 64'(a[11:0]);
        else if (r < 80)
            a = cur_base + (64'(cur_pages + $urandom_range(0, 3)) << PSHIFT) + 64'(a[11:0]);
        else if (r < 90 && cur_base != '0)
            a = cur_base - 64'($urandom_range(1, 4096));
        return a;
    endfunction

    task automatic random_window();
        logic [63:0] base;
        logic [63:0] resv_end;
        logic [12:0] pages;
        int          eff;
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = {40'hFF_FFFF_FFFF, 12'($urandom), 12'h000};
            2:       base = {$urandom, $urandom} & ~64'hFFF;
            default: base = {$urandom, $urandom};
        endcase
        case ($urandom_range(0, 7))
            0:       pages = '0;
            1:       pages = 13'd1;
            5:       pages = 13'(PAGES);
            6:       pages = 13'($urandom_range(PAGES + 1, 8191));
            7:       pages = 13'($urandom_range(0, PAGES));
            default: pages = 13'($urandom_range(2, 130));
        endcase
        eff = (pages > PAGES) ? PAGES : int'(pages);
        case ($urandom_range(0, 4))
            0:       resv_end = '0;
            1:       resv_end = '1;
            4:       resv_end = {$urandom, $urandom};
            default: resv_end = base + 64'($urandom_range(0, eff * 4096 + 8192));
        endcase
        program_window(base, pages, resv_end);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 52)
            send_request(OP_ALLOC, {$urandom, $urandom});
        else if (r < 90)
            send_request(OP_FREE, pick_free_addr());
        else if (r < 95)
            send_request(OP_INIT, {$urandom, $urandom});
        else
            send_request(OP_NOP, {$urandom, $urandom});
    endtask

    initial
    begin
        logic [63:0] base;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config: no pages at all
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        send_request(OP_NOP, '1);
        send_request(OP_INIT, '0);
        drain();

        // reserved end one byte past a word boundary rounds up to 65 pages
        base = 64'h0000_0000_8000_0000;
        program_window(base, 13'd70, base + 64'd64 * 64'd4096 + 64'd1);
        send_request(OP_INIT, '0);
        repeat (6) send_request(OP_ALLOC, '0);
        send_request(OP_FREE, base + 64'd3 * 64'd4096 + 64'h7FF);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, base - 64'd1);
        send_request(OP_FREE, base + 64'd70 * 64'd4096);
        send_request(OP_FREE, base + 64'd69 * 64'd4096);
        send_request(OP_NOP, '0);
        drain();

        // page count above the maximum, result address wraps past 2^64
        base = 64'hFFFF_FFFF_FFFF_F000;
        program_window(base, 13'h1FFF, '0);
        send_request(OP_INIT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '1);
        send_request(OP_ALLOC, '0);
        drain();

        // reserved count saturates at the page count
        program_window('0, 13'd1, '1);
        send_request(OP_INIT, '0);
        send_request(OP_ALLOC, '0);
        send_request(OP_FREE, '0);
        send_request(OP_ALLOC, '0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct = (p == PHASES - 1 || p % 3 == 2) ? 0 : 20;
            random_window();
            if ($urandom_range(0, 4) != 0)
                send_request(OP_INIT, {$urandom, $urandom});
            repeat (PHASE_LEN) random_request();
            drain();
        end

        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("** bitmap_page_frame_allocator: PASSED **");
        else
            $display("** bitmap_page_frame_allocator: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/bpfa_pkg.sv
rtl/core/bpfa_bitmap_mem.sv
rtl/core/bpfa_datapath.sv
rtl/core/bpfa_ctrl.sv
rtl/core/bitmap_page_frame_allocator.sv
sim/bitmap_page_frame_allocator_checker.sv
sim/bitmap_page_frame_allocator_tb.sv
